>>> design/psvf_pkg.sv
package psvf_pkg;

  // Swirl shapes selected by the swirl_type register.
  typedef enum logic [2:0] {
    SW_NONE       = 3'd0,
    SW_SIN_CURL   = 3'd1,
    SW_COS_CURL   = 3'd2,
    SW_SINCOS     = 3'd3,
    SW_COSSIN     = 3'd4,
    SW_SIN_OF_COS = 3'd5,
    SW_COS_OF_SIN = 3'd6
  } swirl_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_SWIRL_TYPE = 3'd0;
  localparam logic [2:0] REG_H_PAMP     = 3'd1;
  localparam logic [2:0] REG_V_PAMP     = 3'd2;
  localparam logic [2:0] REG_H_FREQ     = 3'd3;
  localparam logic [2:0] REG_V_FREQ     = 3'd4;
  localparam logic [2:0] REG_H_SAMP     = 3'd5;
  localparam logic [2:0] REG_V_SAMP     = 3'd6;

  // Reciprocal of two pi in Q32.
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;

  // Polynomial sine coefficients, Q14.
  localparam logic [14:0] SIN_A = 15'd25736;
  localparam logic [13:0] SIN_B = 14'd10512;
  localparam logic [10:0] SIN_C = 11'd1160;

  localparam logic [15:0] QTR_TURN = 16'h4000;

endpackage

>>> design/psvf_sin.sv
module psvf_sin
  import psvf_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        phase,
  output logic signed [15:0] sin_out
);

  logic [14:0] t_in;
  logic [29:0] tt;
  logic [14:0] t0, t2_0, t1, t2_1, t2r;
  logic        neg0, neg1, neg2;
  logic [25:0] m1;
  logic [13:0] r1;
  logic [28:0] m2;
  logic [14:0] r2;
  logic [29:0] m3;

  // Fold the phase into the first quadrant.
  always_comb begin
    t_in = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    tt   = t_in * t_in;
    m1   = t2_0 * SIN_C;
    m2   = t2_1 * r1;
    m3   = t2r * r2;
  end

  // Four stages, one multiply each.
  always_ff @(posedge clk) begin
    if (en) begin
      t0      <= t_in;
      t2_0    <= tt[28:14];
      neg0    <= phase[15];
      t1      <= t0;
      t2_1    <= t2_0;
      r1      <= SIN_B - m1[25:14];
      neg1    <= neg0;
      t2r     <= t1;
      r2      <= SIN_A - m2[28:14];
      neg2    <= neg1;
      sin_out <= neg2 ? -$signed(m3[29:14]) : $signed(m3[29:14]);
    end
  end

endmodule

>>> design/plane_swirl_velocity_field_top.sv
// Channel | Handshake           | Payload
// in      | in_valid, in_stall  | coord_x, coord_y, vel_x, vel_y
// out     | out_valid, out_stall| new_vel_x, new_vel_y
// cfg     | cfg_wen, cfg_addr   | cfg_wdata (write only)
//
// One item enters per clock while in_stall is low. It passes 13 register stages:
// angle multiply, split phase multiply, two four-stage sine units in series,
// offset, plane product and output register.
// Reset (rst, synchronous) clears the valid bits and loads register defaults.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module plane_swirl_velocity_field_top
  import psvf_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [2:0]                    cfg_addr,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic signed [COORD_WIDTH-1:0] vel_x,
  input  logic signed [COORD_WIDTH-1:0] vel_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] new_vel_x,
  output logic signed [COORD_WIDTH-1:0] new_vel_y
);

  localparam int W   = COORD_WIDTH;
  localparam int AW  = W + 17;
  localparam int SW  = ((W > 20) ? W : 20) + 1;
  localparam int PW  = SW + 16;
  localparam int RW  = SW + 2;
  localparam int LAT = 13;

  // Configuration registers.
  swirl_t             swirl_type;
  logic signed [15:0] pamp [2];
  logic        [15:0] freq [2];
  logic        [15:0] samp [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      swirl_type <= SW_NONE;
      pamp[0] <= '0;
      pamp[1] <= '0;
      freq[0] <= 16'd2048;
      freq[1] <= 16'd2048;
      samp[0] <= 16'd2048;
      samp[1] <= 16'd2048;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_SWIRL_TYPE: swirl_type <= swirl_t'(cfg_wdata[2:0]);
        REG_H_PAMP:     pamp[0] <= cfg_wdata;
        REG_V_PAMP:     pamp[1] <= cfg_wdata;
        REG_H_FREQ:     freq[0] <= cfg_wdata;
        REG_V_FREQ:     freq[1] <= cfg_wdata;
        REG_H_SAMP:     samp[0] <= cfg_wdata;
        REG_V_SAMP:     samp[1] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Lane 0 is horizontal (driven by y), lane 1 is vertical (driven by x).
  logic sw_en [2];
  logic in_cos [2];
  logic out_en [2];
  logic out_cos [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sw_en[l]   = 1'b1;
      in_cos[l]  = 1'b0;
      out_en[l]  = 1'b0;
      out_cos[l] = 1'b0;
      unique case (swirl_type)
        SW_SIN_CURL, SW_SINCOS: in_cos[l] = (l == 1);
        SW_COS_CURL, SW_COSSIN: in_cos[l] = (l == 0);
        SW_SIN_OF_COS: begin
          in_cos[l]  = 1'b1;
          out_en[l]  = 1'b1;
          out_cos[l] = (l == 1);
        end
        SW_COS_OF_SIN: begin
          out_en[l]  = 1'b1;
          out_cos[l] = (l == 0);
        end
        default: sw_en[l] = 1'b0;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a result waits.
  logic en;
  logic vld [1:LAT];
  assign en        = !vld[LAT] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= LAT; k++) vld[k] <= vld[k-1];
    end
  end

  // Coordinate and velocity delay lines.
  logic signed [W-1:0] cin [2];
  logic signed [W-1:0] vin [2];
  logic signed [W-1:0] cd [2][1:11];
  logic signed [W-1:0] vd [2][1:12];

  assign cin[0] = coord_y;
  assign cin[1] = coord_x;
  assign vin[0] = vel_x;
  assign vin[1] = vel_y;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        cd[l][1] <= cin[l];
        vd[l][1] <= vin[l];
        for (int k = 2; k <= 11; k++) cd[l][k] <= cd[l][k-1];
        for (int k = 2; k <= 12; k++) vd[l][k] <= vd[l][k-1];
      end
    end
  end

  // Angle and phase: the reciprocal multiply is split in two halves.
  logic signed [AW-1:0] ang [2];
  logic        [54:0]   a55 [2];
  logic        [53:0]   plo_c [2];
  logic        [60:0]   phi_c [2];
  logic        [53:0]   plo [2];
  logic        [30:0]   phi [2];
  logic        [54:0]   psum [2];
  logic        [15:0]   ph_in [2];
  logic signed [15:0]   s_in [2];
  logic signed [15:0]   s_out [2];
  logic        [15:0]   ph_out [2];
  logic signed [15:0]   idl [2][0:3];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      a55[l]   = {{(55 - AW){ang[l][AW-1]}}, ang[l]};
      plo_c[l] = a55[l][23:0] * INV_TWO_PI;
      phi_c[l] = a55[l][54:24] * INV_TWO_PI;
      psum[l]  = {1'b0, plo[l]} + {phi[l], 24'd0} + (55'd1 << 38);
      ph_in[l] = psum[l][54:39] + (in_cos[l] ? QTR_TURN : 16'd0);
      ph_out[l] = {s_in[l][14:0], 1'b0} + (out_cos[l] ? QTR_TURN : 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        ang[l] <= $signed({1'b0, freq[l]}) * cin[l];
        plo[l] <= plo_c[l];
        phi[l] <= phi_c[l][30:0];
        idl[l][0] <= s_in[l];
        for (int k = 1; k < 4; k++) idl[l][k] <= idl[l][k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    psvf_sin u_inner (.clk(clk), .en(en), .phase(ph_in[l]),  .sin_out(s_in[l]));
    psvf_sin u_outer (.clk(clk), .en(en), .phase(ph_out[l]), .sin_out(s_out[l]));
  end

  // Swirl offset, plane product, rounding and saturation.
  logic signed [15:0]   fsel [2];
  logic signed [32:0]   offm [2];
  logic signed [32:0]   offr [2];
  logic signed [SW-1:0] csum [2];
  logic signed [PW-1:0] prod [2];
  logic signed [PW-1:0] prr [2];
  logic signed [RW-1:0] res [2];
  logic signed [RW-1:0] maxv, minv;
  logic signed [W-1:0]  sat [2];

  assign maxv = {{(RW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  assign minv = {{(RW - W + 1){1'b1}}, {(W - 1){1'b0}}};

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fsel[l] = !sw_en[l] ? 16'sd0 : (out_en[l] ? s_out[l] : idl[l][3]);
      offr[l] = (offm[l] + 33'sd4096) >>> 13;
      csum[l] = SW'(cd[l][11]) + SW'($signed(offr[l][19:0]));
      prr[l]  = (prod[l] + PW'(16384)) >>> 15;
      res[l]  = RW'(vd[l][12]) + RW'($signed(prr[l][SW:0]));
      if (res[l] > maxv)      sat[l] = maxv[W-1:0];
      else if (res[l] < minv) sat[l] = minv[W-1:0];
      else                    sat[l] = res[l][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        offm[l] <= $signed({1'b0, samp[l]}) * fsel[l];
        prod[l] <= pamp[l] * csum[l];
      end
      new_vel_x <= sat[0];
      new_vel_y <= sat[1];
    end
  end

endmodule

>>> tb/sv/plane_swirl_velocity_field_checker.sv
`timescale 1ns / 1ps

module plane_swirl_velocity_field_checker
  import psvf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] new_vel_x,
  input  logic signed [15:0] new_vel_y,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } vel_pair_t;

  // Local copy of the register file.
  logic [2:0]  swirl_sel;
  logic [15:0] h_pamp, v_pamp, h_freq, v_freq, h_samp, v_samp;

  vel_pair_t warped_q[$];

  initial pending = 0;

  // Polynomial sine over one quadrant, Q14 in and out.
  function automatic longint quad_sine(longint t);
    longint t2, r;
    t2 = (t * t) >>> 14;
    r = 10512 - ((t2 * 1160) >>> 14);
    r = 25736 - ((t2 * r) >>> 14);
    return (t * r) >>> 14;
  endfunction

  function automatic longint phase_sine(longint phase);
    longint q, f, t, s;
    q = (phase >> 14) & 3;
    f = phase & 16'h3fff;
    t = q[0] ? (16384 - f) : f;
    s = quad_sine(t);
    return q[1] ? -s : s;
  endfunction

  // Angle to a 16-bit turn fraction; wraps modulo 2^64, and bits 54:39 match the hardware's 55-bit sum.
  function automatic longint turn_phase(longint freq, longint coord);
    logic [63:0] p;
    p = 64'(freq * coord) * 64'd683565276 + (64'd1 << 38);
    return longint'(p[54:39]);
  endfunction

  // outer: 0 plain, 1 sin(pi*.), 2 cos(pi*.)
  function automatic longint swirl_shape(bit inner_cos, int outer, longint freq,
                                         longint coord);
    longint v, p2;
    v = phase_sine((turn_phase(freq, coord) + (inner_cos ? 16384 : 0)) & 16'hffff);
    if (outer != 0) begin
      p2 = (v * 2) & 16'hffff;
      v = phase_sine((p2 + (outer == 2 ? 16384 : 0)) & 16'hffff);
    end
    return v;
  endfunction

  function automatic longint swirl_of(bit vertical, longint freq, longint coord);
    case (swirl_t'(swirl_sel))
      SW_SIN_CURL, SW_SINCOS: return swirl_shape(vertical, 0, freq, coord);
      SW_COS_CURL, SW_COSSIN: return swirl_shape(!vertical, 0, freq, coord);
      SW_SIN_OF_COS: return swirl_shape(1'b1, vertical ? 2 : 1, freq, coord);
      SW_COS_OF_SIN: return swirl_shape(1'b0, vertical ? 1 : 2, freq, coord);
      default: return 0;
    endcase
  endfunction

  // Arithmetic shift on longint is a floor shift, so rounding is add-half then shift.
  function automatic logic signed [15:0] sheared_vel(longint vel, longint coord,
      logic signed [15:0] pamp, logic [15:0] samp, longint f);
    longint off, r;
    off = (longint'(samp) * f + (1 << 12)) >>> 13;
    r = vel + ((longint'(pamp) * (coord + off) + (1 << 14)) >>> 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got),
             $signed(want), $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    vel_pair_t p, w;
    if (rst) begin
      swirl_sel <= 3'd0;
      h_pamp <= 16'd0;
      v_pamp <= 16'd0;
      h_freq <= 16'd2048;
      v_freq <= 16'd2048;
      h_samp <= 16'd2048;
      v_samp <= 16'd2048;
      fail_count = 0;
      results_seen = 0;
      warped_q.delete();
    end else begin
      // Predict each accepted item with the registers as they stand.
      if (in_valid && !in_stall) begin
        p.vx = sheared_vel(vel_x, coord_y, h_pamp, h_samp,
                           swirl_of(1'b0, h_freq, coord_y));
        p.vy = sheared_vel(vel_y, coord_x, v_pamp, v_samp,
                           swirl_of(1'b1, v_freq, coord_x));
        warped_q.push_back(p);
      end
      // Compare each accepted result against the oldest prediction.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (warped_q.size() == 0) begin
          $display("unexpected result at %0t", $time);
          fail_count++;
        end else begin
          w = warped_q.pop_front();
          if (new_vel_x !== w.vx) report("new_vel_x", new_vel_x, w.vx);
          if (new_vel_y !== w.vy) report("new_vel_y", new_vel_y, w.vy);
        end
      end
      if (cfg_wen) begin
        case (cfg_addr)
          REG_SWIRL_TYPE: swirl_sel <= cfg_wdata[2:0];
          REG_H_PAMP: h_pamp <= cfg_wdata;
          REG_V_PAMP: v_pamp <= cfg_wdata;
          REG_H_FREQ: h_freq <= cfg_wdata;
          REG_V_FREQ: v_freq <= cfg_wdata;
          REG_H_SAMP: h_samp <= cfg_wdata;
          REG_V_SAMP: v_samp <= cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = warped_q.size();
  end

endmodule

>>> tb/sv/plane_swirl_velocity_field_top_tb.sv
`timescale 1ns / 1ps

module plane_swirl_velocity_field_top_tb;
  import psvf_pkg::*;

  localparam int LATENCY = 13;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] coord_x = '0, coord_y = '0, vel_x = '0, vel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] new_vel_x, new_vel_y;
  int fail_count, pending, results_seen;
  int cycles = 0;
  int items_sent = 0;
  int settings_run = 0;
  bit stim_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  plane_swirl_velocity_field_top u_top (.*);

  plane_swirl_velocity_field_checker u_chk (.*);

  // Short gaps mostly, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result-side stall pattern.
  always @(posedge clk) begin
    int hold;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!stim_done && $urandom_range(0, 99) < 20) begin
      hold = gap_len();
      out_stall <= (hold != 0);
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic send_pixel(logic [15:0] x, logic [15:0] y, logic [15:0] vx,
                            logic [15:0] vy);
    coord_x <= x;
    coord_y <= y;
    vel_x <= vx;
    vel_y <= vy;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_gapped(logic [15:0] x, logic [15:0] y, logic [15:0] vx,
                             logic [15:0] vy, bit gaps);
    int g;
    send_pixel(x, y, vx, vy);
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Lower valid, let the pipeline empty, then wait out the latency.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic program_all(logic [2:0] st, logic [15:0] hp, logic [15:0] vp,
                             logic [15:0] hf, logic [15:0] vf, logic [15:0] hs,
                             logic [15:0] vs);
    write_reg(REG_SWIRL_TYPE, {13'd0, st});
    write_reg(REG_H_PAMP, hp);
    write_reg(REG_V_PAMP, vp);
    write_reg(REG_H_FREQ, hf);
    write_reg(REG_V_FREQ, vf);
    write_reg(REG_H_SAMP, hs);
    write_reg(REG_V_SAMP, vs);
    settings_run++;
  endtask

  initial begin
    logic [15:0] ext[4];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset registers, then extreme coordinates and velocities.
    send_pixel(16'h1000, 16'hf000, 16'h0100, 16'hff00);
    drain();
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    program_all(SW_SIN_OF_COS, 16'h7fff, 16'h8000, 16'hffff, 16'h0000,
                16'hffff, 16'h0000);
    for (int i = 0; i < 4; i++)
      send_pixel(ext[i], ext[3 - i], ext[i], ext[(i + 1) % 4]);
    drain();
    // Saturation on both ends, plus the unused swirl type acting as none.
    program_all(3'd7, 16'h8000, 16'h7fff, 16'h1234, 16'hffff, 16'h0800,
                16'hffff);
    send_pixel(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pixel(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    drain();
    // Out-of-range register index is ignored.
    write_reg(3'd7, 16'hffff);
    for (int st = 0; st <= 6; st++) begin
      write_reg(REG_SWIRL_TYPE, 16'(st));
      send_pixel(16'h0c00, 16'hf400, 16'h0000, 16'h0000);
      send_pixel(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      drain();
    end

    // Random phases: every swirl type, some with extreme registers.
    while (items_sent < 1420) begin
      if (settings_run % 4 == 0)
        program_all(3'($urandom_range(0, 7)), edge_val(), edge_val(), edge_val(),
                    edge_val(), edge_val(), edge_val());
      else
        program_all(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                    16'($urandom_range(0, 8192)), 16'($urandom_range(0, 8192)),
                    16'($urandom_range(0, 8192)), 16'($urandom_range(0, 8192)));
      for (int n = $urandom_range(40, 120); n > 0; n--)
        send_gapped(edge_val(), edge_val(), edge_val(), edge_val(),
                    (settings_run % 3) != 1);
      drain();
    end
    stim_done = 1'b1;

    $display("covered %0d pixels, %0d results, %0d register settings",
             items_sent, results_seen, settings_run);
    $display("all swirl types, saturating edges, and random stalls on both sides");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
